FILE: rtl/core/las_pkg.sv
// Shared types and constants for the LED animation sequencer.
// Item, result and program-entry layouts, and controller/datapath command structs.
// No dependencies.
`default_nettype none

package las_pkg;

	localparam int NUM_LEDS         = 12;
	localparam int NUM_COLORS       = 3;
	localparam int RIGHT_HALF_START = 6;
	localparam int LEVEL_W          = 4;
	localparam int VAL_W            = 5;

	// Item modes
	localparam logic [1:0] MODE_TICK    = 2'd0;
	localparam logic [1:0] MODE_WRITE   = 2'd1;
	localparam logic [1:0] MODE_RESTART = 2'd2;

	// Opcode bit positions; all clear means load
	localparam int OP_ADD_BIT      = 0;
	localparam int OP_ROT_UP_BIT   = 1;
	localparam int OP_ROT_DOWN_BIT = 2;
	localparam int OP_HALF_UP_BIT  = 3;
	localparam int OP_REPEAT_BIT   = 5;

	localparam logic [7:0] NO_STEP = 8'hFF;

	// Configuration registers
	localparam int         CFG_IDX_W       = 1;
	localparam int         CFG_DATA_W      = 8;
	localparam logic       REG_ANIM_START  = 1'b0;
	localparam logic       REG_ANIM_LENGTH = 1'b1;
	localparam logic [7:0] ANIM_LENGTH_RST = 8'd1;

	typedef logic [LEVEL_W-1:0] level_t;

	typedef struct packed {
		logic [7:0]                  entry_repeat;
		logic [5:0]                  entry_opcode;
		logic [NUM_COLORS*VAL_W-1:0] entry_rgb_values;
		logic [NUM_LEDS*VAL_W-1:0]   entry_led_values;
		logic [15:0]                 entry_duration;
		logic [6:0]                  entry_addr;
		logic [15:0]                 elapsed_ms;
		logic [1:0]                  mode;
	} item_t;

	typedef struct packed {
		logic                          step_applied;
		logic [6:0]                    step_index;
		logic [NUM_COLORS*LEVEL_W-1:0] rgb_levels;
		logic [NUM_LEDS*LEVEL_W-1:0]   led_levels;
	} result_t;

	typedef struct packed {
		logic [7:0]                  repeat_cnt;
		logic [5:0]                  opcode;
		logic [NUM_COLORS*VAL_W-1:0] rgb_values;
		logic [NUM_LEDS*VAL_W-1:0]   led_values;
		logic [15:0]                 duration;
	} prog_entry_t;

	typedef struct packed {
		logic take_item;
		logic prog_write;
		logic restart;
		logic tick_begin;
		logic reduce;
		logic walk_init;
		logic walk_step;
		logic fetch;
		logic apply;
		logic out_load;
	} las_cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       tick_nonzero;
		logic       start_ge_depth;
		logic       walk_hit;
		logic       walk_end;
	} las_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/las_if.sv
// Valid/ready channel interfaces for input items and results.
// Depends on las_pkg for the payload types.
`default_nettype none

interface las_item_if import las_pkg::*;;
	logic  valid;
	logic  ready;
	item_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface las_result_if import las_pkg::*;;
	logic    valid;
	logic    ready;
	result_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/las_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module las_ram #(
	parameter  int WIDTH = 8,
	parameter  int DEPTH = 16,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

FILE: rtl/core/las_ctrl.sv
// Controller state machine of the LED animation sequencer.
// Sequences decode, start reduction, timeline walk, fetch and apply. Uses las_pkg.
`default_nettype none

module las_ctrl import las_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	output logic        result_valid,
	input  logic        result_ready,
	input  las_status_t sts,
	output las_cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_REDUCE,
		S_WALK,
		S_FETCH,
		S_APPLY,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   result_valid_q;
	logic   finish;
	logic   is_tick;

	assign is_tick = (sts.mode == MODE_TICK) && sts.tick_nonzero;

	always_comb begin
		cmd    = '0;
		finish = 1'b0;
		unique case (state_q)
			S_IDLE: cmd.take_item = item_valid;
			S_DECODE: begin
				cmd.prog_write = (sts.mode == MODE_WRITE);
				cmd.restart    = (sts.mode == MODE_RESTART);
				cmd.tick_begin = is_tick;
			end
			S_REDUCE: begin
				cmd.reduce    = sts.start_ge_depth;
				cmd.walk_init = !sts.start_ge_depth;
			end
			S_WALK:  cmd.walk_step = 1'b1;
			S_FETCH: cmd.fetch = 1'b1;
			S_APPLY: cmd.apply = 1'b1;
			S_FINISH: begin
				finish       = !result_valid_q || result_ready;
				cmd.out_load = finish;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			if (finish) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE:   if (item_valid) state_q <= S_DECODE;
				S_DECODE: state_q <= is_tick ? S_REDUCE : S_FINISH;
				S_REDUCE: if (!sts.start_ge_depth) state_q <= S_WALK;
				S_WALK:   if (sts.walk_hit || sts.walk_end) state_q <= S_FETCH;
				S_FETCH:  state_q <= S_APPLY;
				S_APPLY:  state_q <= S_FINISH;
				S_FINISH: if (finish) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = result_valid_q;

endmodule

`default_nettype wire

FILE: rtl/core/las_dp.sv
// Datapath of the LED animation sequencer: config registers, program RAM,
// timer, timeline walk, step apply logic and result register. Uses las_pkg, las_ram.
`default_nettype none

module las_dp import las_pkg::*; #(
	parameter int PROG_DEPTH = 128
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  las_cmd_t              cmd,
	output las_status_t           sts,
	input  item_t                 item_payload,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output result_t               result_payload
);

	localparam int AW      = $clog2(PROG_DEPTH);
	localparam int START_W = 9;
	localparam logic [AW-1:0]      LAST_ADDR   = AW'(PROG_DEPTH - 1);
	localparam logic [START_W-1:0] DEPTH_START = START_W'(PROG_DEPTH);

	// Configuration
	logic [6:0] anim_start_q;
	logic [7:0] anim_length_q;

	// Animation state
	logic [15:0]                            timer_q;
	logic [7:0]                             last_q;
	logic [7:0]                             rc_q;
	logic [NUM_LEDS-1:0][LEVEL_W-1:0]       led_q;
	logic [NUM_COLORS-1:0][LEVEL_W-1:0]     rgb_q;
	logic                                   tick_q;
	logic                                   applied_q;

	// Item and walk registers
	item_t              item_q;
	logic [START_W-1:0] start_q;
	logic [7:0]         walk_idx_q;
	logic [AW-1:0]      walk_addr_q;
	logic               cmp_valid_q;
	logic [7:0]         cmp_idx_q;
	logic [AW-1:0]      cmp_addr_q;
	logic [15:0]        sum_q;
	logic [7:0]         sel_idx_q;
	logic [AW-1:0]      sel_addr_q;
	result_t            result_q;

	// RAM signals
	prog_entry_t wr_entry;
	prog_entry_t rd_entry;
	logic        ram_we;
	logic        ram_re;
	logic [AW-1:0] ram_raddr;
	logic        addr_ok;

	// Walk and apply logic
	logic [15:0] sum_next;
	logic        walk_hit;
	logic        walk_end;
	logic        issue;
	logic        do_apply;
	logic [5:0]  op;
	logic [NUM_LEDS-1:0][LEVEL_W-1:0]   a_led, b_led, c_led, d_led, ld_led, new_led;
	logic [NUM_COLORS-1:0][LEVEL_W-1:0] a_rgb, ld_rgb, new_rgb;

	function automatic level_t add_level(input level_t lvl, input logic [VAL_W-1:0] inc);
		logic [VAL_W:0] sum;
		sum = {2'b00, lvl} + {inc[VAL_W-1], inc};
		return (sum[VAL_W:LEVEL_W] == '0) ? sum[LEVEL_W-1:0] : '0;
	endfunction

	function automatic level_t load_level(input logic [VAL_W-1:0] v);
		return v[VAL_W-1] ? '0 : v[LEVEL_W-1:0];
	endfunction

	assign addr_ok = START_W'(item_q.entry_addr) < DEPTH_START;

	assign wr_entry.repeat_cnt = item_q.entry_repeat;
	assign wr_entry.opcode     = item_q.entry_opcode;
	assign wr_entry.rgb_values = item_q.entry_rgb_values;
	assign wr_entry.led_values = item_q.entry_led_values;
	assign wr_entry.duration   = item_q.entry_duration;

	assign ram_we    = cmd.prog_write && addr_ok;
	assign ram_re    = cmd.walk_step || cmd.fetch;
	assign ram_raddr = cmd.fetch ? sel_addr_q : walk_addr_q;

	las_ram #(
		.WIDTH($bits(prog_entry_t)),
		.DEPTH(PROG_DEPTH)
	) u_prog_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(AW'(item_q.entry_addr)),
		.wr_data(wr_entry),
		.rd_en  (ram_re),
		.rd_addr(ram_raddr),
		.rd_data(rd_entry)
	);

	// Timeline walk: one duration read per cycle, compared in the cycle after its read
	assign sum_next = sum_q + rd_entry.duration;
	assign walk_hit = cmp_valid_q && (sum_next > timer_q);
	assign walk_end = !cmp_valid_q && (walk_idx_q >= anim_length_q);
	assign issue    = (walk_idx_q < anim_length_q) && !walk_hit;

	assign sts.mode           = item_q.mode;
	assign sts.tick_nonzero   = (item_q.elapsed_ms != '0);
	assign sts.start_ge_depth = (start_q >= DEPTH_START);
	assign sts.walk_hit       = walk_hit;
	assign sts.walk_end       = walk_end;

	// Step operations in fixed order: add, rotate up, rotate down, half up-rotate
	assign op       = rd_entry.opcode;
	assign do_apply = (last_q != sel_idx_q);

	always_comb begin
		for (int i = 0; i < NUM_LEDS; i++) begin
			ld_led[i] = load_level(rd_entry.led_values[VAL_W*i +: VAL_W]);
			a_led[i]  = op[OP_ADD_BIT] ?
				add_level(led_q[i], rd_entry.led_values[VAL_W*i +: VAL_W]) : led_q[i];
		end
		for (int i = 0; i < NUM_COLORS; i++) begin
			ld_rgb[i] = load_level(rd_entry.rgb_values[VAL_W*i +: VAL_W]);
			a_rgb[i]  = op[OP_ADD_BIT] ?
				add_level(rgb_q[i], rd_entry.rgb_values[VAL_W*i +: VAL_W]) : rgb_q[i];
		end
		for (int i = 0; i < NUM_LEDS; i++) begin
			if (!op[OP_ROT_UP_BIT]) begin
				b_led[i] = a_led[i];
			end else if (i == 0) begin
				b_led[i] = a_led[NUM_LEDS-1];
			end else begin
				b_led[i] = a_led[i-1];
			end
		end
		for (int i = 0; i < NUM_LEDS; i++) begin
			if (!op[OP_ROT_DOWN_BIT]) begin
				c_led[i] = b_led[i];
			end else if (i == NUM_LEDS-1) begin
				c_led[i] = b_led[0];
			end else begin
				c_led[i] = b_led[i+1];
			end
		end
		for (int i = 0; i < NUM_LEDS; i++) begin
			if (!op[OP_HALF_UP_BIT]) begin
				d_led[i] = c_led[i];
			end else if (i < RIGHT_HALF_START) begin
				if (i == 0) begin
					d_led[i] = c_led[RIGHT_HALF_START-1];
				end else begin
					d_led[i] = c_led[i-1];
				end
			end else if (i == NUM_LEDS-1) begin
				d_led[i] = c_led[RIGHT_HALF_START];
			end else begin
				d_led[i] = c_led[i+1];
			end
		end
		new_led = (op == '0) ? ld_led : d_led;
		new_rgb = (op == '0) ? ld_rgb : a_rgb;
	end

	// Control and animation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anim_start_q  <= '0;
			anim_length_q <= ANIM_LENGTH_RST;
			timer_q       <= '0;
			last_q        <= NO_STEP;
			rc_q          <= '0;
			led_q         <= '0;
			rgb_q         <= '0;
			tick_q        <= 1'b0;
			applied_q     <= 1'b0;
			cmp_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_index == REG_ANIM_START) begin
					anim_start_q <= cfg_data[6:0];
				end else begin
					anim_length_q <= cfg_data;
				end
			end
			if (cmd.take_item) begin
				tick_q    <= 1'b0;
				applied_q <= 1'b0;
			end
			if (cmd.restart) begin
				timer_q <= '0;
				last_q  <= NO_STEP;
				rc_q    <= '0;
			end
			if (cmd.tick_begin) begin
				tick_q  <= 1'b1;
				timer_q <= timer_q + item_q.elapsed_ms;
			end
			if (cmd.walk_init) begin
				cmp_valid_q <= 1'b0;
			end
			if (cmd.walk_step) begin
				cmp_valid_q <= issue;
				// run ended without a qualifying step: wrap to step 0
				if (walk_end) begin
					timer_q <= '0;
				end
			end
			if (cmd.apply && do_apply) begin
				applied_q <= 1'b1;
				led_q     <= new_led;
				rgb_q     <= new_rgb;
				if (op == '0 || !op[OP_REPEAT_BIT]) begin
					last_q <= sel_idx_q;
				end else if (rc_q == '0) begin
					rc_q    <= rd_entry.repeat_cnt;
					timer_q <= timer_q - rd_entry.duration;
				end else begin
					rc_q <= rc_q - 8'd1;
					if (rc_q != 8'd1) begin
						timer_q <= timer_q - rd_entry.duration;
					end else begin
						last_q <= sel_idx_q;
					end
				end
			end
		end
	end

	// Payload and walk registers
	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			item_q <= item_payload;
		end
		if (cmd.tick_begin) begin
			start_q <= START_W'(anim_start_q);
		end
		if (cmd.reduce) begin
			start_q <= start_q - DEPTH_START;
		end
		if (cmd.walk_init) begin
			walk_idx_q  <= '0;
			walk_addr_q <= AW'(start_q);
			sum_q       <= '0;
		end
		if (cmd.walk_step) begin
			cmp_idx_q  <= walk_idx_q;
			cmp_addr_q <= walk_addr_q;
			if (cmp_valid_q) begin
				sum_q <= sum_next;
			end
			if (issue) begin
				walk_idx_q  <= walk_idx_q + 8'd1;
				walk_addr_q <= (walk_addr_q == LAST_ADDR) ? '0 : walk_addr_q + 1'b1;
			end
			if (walk_hit) begin
				sel_idx_q  <= cmp_idx_q;
				sel_addr_q <= cmp_addr_q;
			end else if (walk_end) begin
				sel_idx_q  <= '0;
				sel_addr_q <= AW'(start_q);
			end
		end
		if (cmd.out_load) begin
			result_q.led_levels   <= led_q;
			result_q.rgb_levels   <= rgb_q;
			result_q.step_index   <= tick_q ? sel_idx_q[6:0] : '0;
			result_q.step_applied <= applied_q;
		end
	end

	assign result_payload = result_q;

endmodule

`default_nettype wire

FILE: rtl/core/led_animation_sequencer.sv
// LED animation sequencer: usage notes.
//
// Channels: "item" (valid/ready sink) takes ticks, program-entry writes and
// restarts; "result" (valid/ready source) returns exactly one result per item.
// The cfg_* port writes anim_start (index 0) and anim_length (index 1); write
// it only while the block is idle.
// Item flow: one item at a time; ready drops after each transfer.
// A write, restart, zero tick or unused mode goes straight from decode to
// finish. A nonzero tick first folds anim_start by PROG_DEPTH, then walks the
// timeline, reading step durations from the program RAM (at most anim_length,
// one per cycle through its single read port), then fetches and applies the
// selected step. With no result waiting, the result is presented in the cycle
// that ready returns.
// Result register: the next item is taken while a finished result still waits;
// when the receiver stalls, the block holds the following result and stops
// taking items until the waiting result is transferred.
// Reset: timer, levels and repeat count clear, last step reads "no step";
// the program RAM is not cleared and must be written before use.
// Uses las_pkg, las_if, las_ctrl, las_dp, las_ram.
`default_nettype none

module led_animation_sequencer import las_pkg::*; #(
	parameter int PROG_DEPTH = 128
) (
	input  logic                  clk,
	input  logic                  arst_n,
	las_item_if.sink              item,
	las_result_if.source          result,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	las_cmd_t    cmd;
	las_status_t sts;

	// Controller: owns handshakes and sequencing
	las_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item.valid),
		.item_ready  (item.ready),
		.result_valid(result.valid),
		.result_ready(result.ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	// Datapath: program store, timer, walk and level state
	las_dp #(
		.PROG_DEPTH(PROG_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.item_payload  (item.payload),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.result_payload(result.payload)
	);

	// Drop ready right after a transfer: one item in flight
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> !item.ready)
		else $error("item accepted while another is in flight");

	// A finished walk always goes on to fetch the selected step
	a_walk_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_step && (sts.walk_end || sts.walk_hit) |=> cmd.fetch)
		else $error("walk finished without fetching the step");

	// Loading the result register presents it on the next cycle
	a_out_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> result.valid)
		else $error("loaded result not presented");

	// Never write the program RAM while it is being read for a walk or fetch
	a_ram_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.prog_write && (cmd.walk_step || cmd.fetch)))
		else $error("program write collides with a read");

endmodule

`default_nettype wire
